[src/fcu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fcu_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int COORD_W       = 24;
    localparam int LINK_W        = 23;
    localparam int GAIN_W        = 16;
    localparam int ACT_W         = 6;
    localparam int NIDX_W        = 5;
    localparam int PADDR_W       = 4;
    localparam int MUL_W         = 25;
    localparam int PROD_W        = 50;
    localparam int ROOT_W        = 32;
    localparam int OPND_W        = 64;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_LINK = 2'd0;
    localparam logic [1:0] REG_GAIN = 2'd1;
    localparam logic [1:0] REG_ACT  = 2'd2;

    localparam logic [LINK_W-1:0] LINK_RST = 23'd12800;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd131;
    localparam logic [ACT_W-1:0]  ACT_RST  = 6'd21;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD,
        ST_LOAD,
        ST_HMX,
        ST_HAX,
        ST_HMY,
        ST_HAY,
        ST_MXX,
        ST_MYY,
        ST_SUM,
        ST_SQS,
        ST_SQW,
        ST_MLX,
        ST_DXS,
        ST_DXW,
        ST_MLY,
        ST_DYS,
        ST_DYW,
        ST_ZERO,
        ST_WR,
        ST_ERD,
        ST_ELD
    } fcu_state_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } fcu_op_t;

    typedef struct packed {
        logic    start;
        fcu_op_t op;
    } fcu_cmd_t;

    function automatic logic [COORD_W-1:0] sat24(input logic signed [33:0] v);
        logic [COORD_W-1:0] r;
        if (v > 34'sd8388607)
        begin
            r = 24'h7FFFFF;
        end
        else if (v < -34'sd8388608)
        begin
            r = 24'h800000;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // power-up x position of node i: (1 - 50*i) in Q16.8
    function automatic logic [COORD_W-1:0] node_x_rst(input logic [7:0] i);
        int v;
        v = (1 - 50 * int'(i)) * 256;
        return sat24(34'(v));
    endfunction

endpackage

`default_nettype wire

[src/follow_chain_update_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// follow_chain_update_core: a chain of nodes that trails a target point.
// Input stream (s_*): one word = target (x, y), signed Q16.8. The head node
// steps toward it by follow_gain; each follower is then put link_length
// away from its predecessor along the line to its old position.
// Output stream (m_*): after the update, one word per active node in order
// (index, x, y); m_tlast marks the final node.
// APB port: link_length @0x0, follow_gain @0x4, active_nodes @0x8. Write
// only while idle.
// Work: the head needs only the multiplier; each follower (unless it sits on
// its predecessor) also uses the shared root/divide unit (32 steps for the
// square root, then two 64-step divides). s_tready is high only between items.
// Reset: node positions return to their power-up layout through per-node
// valid bits (no clearing pass); registers get their reset values.
// Stall: the output word sits in a register; the block waits for m_tready
// and loses nothing. The next target can be taken while the last word waits.
module follow_chain_update_core
#(
    parameter int MAX_NODES = fcu_pkg::MAX_NODES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [47:0]                   s_tdata,   // target_x, target_y
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [55:0]                        m_tdata,   // node_index, node_x, node_y, pad
    output logic                               m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fcu_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int LIM   = (MAX_NODES < 32) ? MAX_NODES : 32;

    // ---------------- configuration ----------------
    logic [fcu_pkg::LINK_W-1:0] link_reg;
    logic [fcu_pkg::GAIN_W-1:0] gain_reg;
    logic [fcu_pkg::ACT_W-1:0]  act_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= fcu_pkg::LINK_RST;
            gain_reg <= fcu_pkg::GAIN_RST;
            act_reg  <= fcu_pkg::ACT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                fcu_pkg::REG_LINK: link_reg <= pwdata[fcu_pkg::LINK_W-1:0];
                fcu_pkg::REG_GAIN: gain_reg <= pwdata[fcu_pkg::GAIN_W-1:0];
                fcu_pkg::REG_ACT:  act_reg  <= pwdata[fcu_pkg::ACT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fcu_pkg::REG_LINK: prdata = 32'(link_reg);
            fcu_pkg::REG_GAIN: prdata = 32'(gain_reg);
            fcu_pkg::REG_ACT:  prdata = 32'(act_reg);
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer state ----------------
    fcu_pkg::fcu_state_t state_reg;
    fcu_pkg::fcu_state_t state_next;

    logic signed [23:0]          tx_reg;
    logic signed [23:0]          ty_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            idx_inc;
    logic                        idx_last;
    logic signed [23:0]          cur_x_reg;
    logic signed [23:0]          cur_y_reg;
    logic signed [23:0]          px_reg;
    logic signed [23:0]          py_reg;
    logic [23:0]                 new_x_reg;
    logic [23:0]                 new_y_reg;
    logic [fcu_pkg::PROD_W-1:0]  prod_reg;
    logic [fcu_pkg::PROD_W-1:0]  m2_reg;
    logic [fcu_pkg::ROOT_W-1:0]  s_reg;

    // node store with power-up fallback
    logic [23:0]                 mem_x [MAX_NODES];
    logic [23:0]                 mem_y [MAX_NODES];
    logic [MAX_NODES-1:0]        valid_reg;
    logic [23:0]                 rd_x_reg;
    logic [23:0]                 rd_y_reg;
    logic                        rd_valid_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic [23:0]                 eff_x;
    logic [23:0]                 eff_y;

    // output register
    logic                        out_valid_reg;
    logic [55:0]                 out_data_reg;
    logic                        out_last_reg;

    // controls from the output decoder
    logic                        accept;
    logic                        mem_we;
    logic                        out_load;
    fcu_pkg::fcu_cmd_t           u_cmd;
    logic [fcu_pkg::OPND_W-1:0]  u_operand;
    logic                        u_done;
    logic                        u_busy;
    logic [fcu_pkg::ROOT_W-1:0]  u_result;

    logic [6:0]                  cnt_clamp;

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_last = (idx_inc == cnt_reg);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (act_reg == '0)
        begin
            cnt_clamp = 7'd1;
        end
        else if (int'(act_reg) > LIM)
        begin
            cnt_clamp = 7'(LIM);
        end
        else
        begin
            cnt_clamp = 7'(act_reg);
        end
    end

    // ---------------- datapath helpers ----------------
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] vx;
    logic signed [24:0] vy;
    logic [24:0]        mdx;
    logic [24:0]        mdy;
    logic [24:0]        ax;
    logic [24:0]        ay;
    logic [fcu_pkg::MUL_W-1:0] mul_a;
    logic [fcu_pkg::MUL_W-1:0] mul_b;
    logic [25:0]        hstep;
    logic signed [33:0] st34;
    logic signed [33:0] cx34;
    logic signed [33:0] cy34;
    logic signed [33:0] px34;
    logic signed [33:0] py34;
    logic signed [33:0] q34;
    logic signed [33:0] hsum_x;
    logic signed [33:0] hsum_y;
    logic signed [33:0] fsum_x;
    logic signed [33:0] fsum_y;
    logic signed [33:0] zsum_x;

    assign eff_x = rd_valid_reg ? rd_x_reg : fcu_pkg::node_x_rst(8'(rd_idx_reg));
    assign eff_y = rd_valid_reg ? rd_y_reg : 24'd256;

    assign dx  = 25'(tx_reg) - 25'(cur_x_reg);
    assign dy  = 25'(ty_reg) - 25'(cur_y_reg);
    assign vx  = 25'(px_reg) - 25'(cur_x_reg);
    assign vy  = 25'(py_reg) - 25'(cur_y_reg);
    assign mdx = dx[24] ? 25'(-dx) : 25'(dx);
    assign mdy = dy[24] ? 25'(-dy) : 25'(dy);
    assign ax  = vx[24] ? 25'(-vx) : 25'(vx);
    assign ay  = vy[24] ? 25'(-vy) : 25'(vy);

    // head step: round half away from zero of |d|*gain / 2^16
    assign hstep = 26'((prod_reg[40:0] + 41'd32768) >> 16);
    assign st34  = $signed({8'd0, hstep});
    assign cx34  = 34'(cur_x_reg);
    assign cy34  = 34'(cur_y_reg);
    assign px34  = 34'(px_reg);
    assign py34  = 34'(py_reg);
    assign q34   = $signed({2'b00, u_result});

    assign hsum_x = dx[24] ? cx34 - st34 : cx34 + st34;
    assign hsum_y = dy[24] ? cy34 - st34 : cy34 + st34;
    assign fsum_x = vx[24] ? px34 + q34 : px34 - q34;
    assign fsum_y = vy[24] ? py34 + q34 : py34 - q34;
    assign zsum_x = px34 - $signed(34'(link_reg));

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            fcu_pkg::ST_HMX:
            begin
                mul_a = mdx;
                mul_b = 25'(gain_reg);
            end
            fcu_pkg::ST_HMY:
            begin
                mul_a = mdy;
                mul_b = 25'(gain_reg);
            end
            fcu_pkg::ST_MXX:
            begin
                mul_a = ax;
                mul_b = ax;
            end
            fcu_pkg::ST_MYY:
            begin
                mul_a = ay;
                mul_b = ay;
            end
            fcu_pkg::ST_MLX:
            begin
                mul_a = ax;
                mul_b = 25'(link_reg);
            end
            fcu_pkg::ST_MLY:
            begin
                mul_a = ay;
                mul_b = 25'(link_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcu_pkg::ST_IDLE: if (accept) state_next = fcu_pkg::ST_RD;
            fcu_pkg::ST_RD:   state_next = fcu_pkg::ST_LOAD;
            fcu_pkg::ST_LOAD:
            begin
                state_next = (idx_reg == '0) ? fcu_pkg::ST_HMX : fcu_pkg::ST_MXX;
            end
            fcu_pkg::ST_HMX:  state_next = fcu_pkg::ST_HAX;
            fcu_pkg::ST_HAX:  state_next = fcu_pkg::ST_HMY;
            fcu_pkg::ST_HMY:  state_next = fcu_pkg::ST_HAY;
            fcu_pkg::ST_HAY:  state_next = fcu_pkg::ST_WR;
            fcu_pkg::ST_MXX:  state_next = fcu_pkg::ST_MYY;
            fcu_pkg::ST_MYY:  state_next = fcu_pkg::ST_SUM;
            fcu_pkg::ST_SUM:  state_next = fcu_pkg::ST_SQS;
            fcu_pkg::ST_SQS:
            begin
                state_next = (m2_reg == '0) ? fcu_pkg::ST_ZERO : fcu_pkg::ST_SQW;
            end
            fcu_pkg::ST_SQW:  if (u_done) state_next = fcu_pkg::ST_MLX;
            fcu_pkg::ST_MLX:  state_next = fcu_pkg::ST_DXS;
            fcu_pkg::ST_DXS:  state_next = fcu_pkg::ST_DXW;
            fcu_pkg::ST_DXW:  if (u_done) state_next = fcu_pkg::ST_MLY;
            fcu_pkg::ST_MLY:  state_next = fcu_pkg::ST_DYS;
            fcu_pkg::ST_DYS:  state_next = fcu_pkg::ST_DYW;
            fcu_pkg::ST_DYW:  if (u_done) state_next = fcu_pkg::ST_WR;
            fcu_pkg::ST_ZERO: state_next = fcu_pkg::ST_WR;
            fcu_pkg::ST_WR:
            begin
                state_next = idx_last ? fcu_pkg::ST_ERD : fcu_pkg::ST_RD;
            end
            fcu_pkg::ST_ERD:  state_next = fcu_pkg::ST_ELD;
            fcu_pkg::ST_ELD:
            begin
                if (out_load)
                begin
                    state_next = idx_last ? fcu_pkg::ST_IDLE : fcu_pkg::ST_ERD;
                end
            end
            default:          state_next = fcu_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        u_cmd     = '{start: 1'b0, op: fcu_pkg::OP_SQRT};
        u_operand = '0;
        case (state_reg)
            fcu_pkg::ST_IDLE: s_tready = 1'b1;
            fcu_pkg::ST_SQS:
            begin
                u_cmd.start = (m2_reg != '0);
                u_operand   = {m2_reg, 14'd0};
            end
            fcu_pkg::ST_DXS,
            fcu_pkg::ST_DYS:
            begin
                u_cmd     = '{start: 1'b1, op: fcu_pkg::OP_DIV};
                u_operand = (64'(prod_reg) << 7) + 64'(s_reg[fcu_pkg::ROOT_W-1:1]);
            end
            fcu_pkg::ST_WR:   mem_we = 1'b1;
            fcu_pkg::ST_ELD:  out_load = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcu_pkg::ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                idx_reg <= '0;
                cnt_reg <= CNT_W'(cnt_clamp);
            end
            else if (mem_we)
            begin
                idx_reg <= idx_last ? '0 : idx_inc;
            end
            else if (out_load)
            begin
                idx_reg <= idx_inc;
            end
            if (mem_we)
            begin
                valid_reg[idx_reg[IDX_W-1:0]] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[idx_reg[IDX_W-1:0]] <= new_x_reg;
            mem_y[idx_reg[IDX_W-1:0]] <= new_y_reg;
        end
        rd_x_reg     <= mem_x[idx_reg[IDX_W-1:0]];
        rd_y_reg     <= mem_y[idx_reg[IDX_W-1:0]];
        rd_valid_reg <= valid_reg[idx_reg[IDX_W-1:0]];
        rd_idx_reg   <= idx_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            tx_reg <= s_tdata[23:0];
            ty_reg <= s_tdata[47:24];
        end
        case (state_reg)
            fcu_pkg::ST_LOAD:
            begin
                cur_x_reg <= eff_x;
                cur_y_reg <= eff_y;
            end
            fcu_pkg::ST_HAX: new_x_reg <= fcu_pkg::sat24(hsum_x);
            fcu_pkg::ST_HAY: new_y_reg <= fcu_pkg::sat24(hsum_y);
            fcu_pkg::ST_MYY: m2_reg <= prod_reg;
            fcu_pkg::ST_SUM: m2_reg <= m2_reg + prod_reg;
            fcu_pkg::ST_SQW: if (u_done) s_reg <= u_result;
            fcu_pkg::ST_DXW: if (u_done) new_x_reg <= fcu_pkg::sat24(fsum_x);
            fcu_pkg::ST_DYW: if (u_done) new_y_reg <= fcu_pkg::sat24(fsum_y);
            fcu_pkg::ST_ZERO:
            begin
                new_x_reg <= fcu_pkg::sat24(zsum_x);
                new_y_reg <= py_reg;
            end
            fcu_pkg::ST_WR:
            begin
                px_reg <= new_x_reg;
                py_reg <= new_y_reg;
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_data_reg <= {3'b000, eff_y, eff_x, 5'(rd_idx_reg)};
            out_last_reg <= idx_last;
        end
    end

    fcu_root_div u_root_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (u_cmd),
        .operand (u_operand),
        .divisor (s_reg),
        .done    (u_done),
        .busy    (u_busy),
        .result  (u_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> (state_reg == fcu_pkg::ST_SQW || state_reg == fcu_pkg::ST_DXW ||
                    state_reg == fcu_pkg::ST_DYW))
        else $error("unit finished outside a wait state");

    a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !u_busy)
        else $error("item taken while unit busy");
`endif

endmodule

`default_nettype wire

[src/fcu_root_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shift-subtract unit: floor square root of a 64-bit word (2 bits/cycle)
// or 64-by-32 unsigned divide (1 bit/cycle, low 32 quotient bits kept).
module fcu_root_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fcu_pkg::fcu_cmd_t             cmd,
    input  wire logic [fcu_pkg::OPND_W-1:0]    operand,
    input  wire logic [fcu_pkg::ROOT_W-1:0]    divisor,
    output logic                               done,
    output logic                               busy,
    output logic [fcu_pkg::ROOT_W-1:0]         result
);

    localparam logic [6:0] SQRT_STEPS = 7'd32;
    localparam logic [6:0] DIV_STEPS  = 7'd64;

    logic                          busy_reg;
    logic                          done_reg;
    fcu_pkg::fcu_op_t              op_reg;
    logic [fcu_pkg::OPND_W-1:0]    work_reg;
    logic [35:0]                   rem_reg;
    logic [fcu_pkg::ROOT_W-1:0]    res_reg;
    logic [fcu_pkg::ROOT_W-1:0]    div_reg;
    logic [6:0]                    cnt_reg;

    logic [35:0] a;
    logic [35:0] b;
    logic [35:0] diff;
    logic        ge;

    always_comb
    begin
        if (op_reg == fcu_pkg::OP_SQRT)
        begin
            a = {rem_reg[33:0], work_reg[63:62]};
            b = {2'b00, res_reg, 2'b01};
        end
        else
        begin
            a = {rem_reg[34:0], work_reg[63]};
            b = {4'b0000, div_reg};
        end
        ge   = (a >= b);
        diff = a - b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (cmd.op == fcu_pkg::OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && cmd.start)
        begin
            op_reg   <= cmd.op;
            work_reg <= operand;
            div_reg  <= divisor;
            rem_reg  <= '0;
            res_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : a;
            res_reg <= {res_reg[fcu_pkg::ROOT_W-2:0], ge};
            if (op_reg == fcu_pkg::OP_SQRT)
            begin
                work_reg <= {work_reg[61:0], 2'b00};
            end
            else
            begin
                work_reg <= {work_reg[62:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign busy   = busy_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[test/follow_chain_check.sv]
`timescale 1ns / 1ps
`default_nettype none

// Watches the target, node and APB channels; predicts each chain update
// and compares every node word against it.
module follow_chain_check
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               words_pending
);

    typedef struct packed {
        logic [4:0]  idx;
        logic [23:0] x;
        logic [23:0] y;
        logic        last;
    } node_word_t;

    node_word_t node_q[$];

    logic signed [23:0] chain_x [32];
    logic signed [23:0] chain_y [32];
    logic [22:0] link_len;
    logic [15:0] gain;
    logic [5:0]  n_active;

    assign words_pending = node_q.size();

    function automatic logic signed [23:0] clamp_q16(input longint v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    // one head step toward the target, returns the new coordinate
    function automatic logic signed [23:0] head_step(input longint tgt, input longint cur);
        longint d;
        longint unsigned m;
        d = tgt - cur;
        m = ((d < 0 ? -d : d) * longint'(gain) + 32768) >> 16;
        return clamp_q16(cur + (d < 0 ? -longint'(m) : longint'(m)));
    endfunction

    task automatic advance_chain(input logic signed [23:0] tx, input logic signed [23:0] ty);
        int count;
        longint px, py, vx, vy;
        longint unsigned ax, ay, m2, root, qx, qy;
        node_word_t w;
        count = int'(n_active);
        if (count < 1)
            count = 1;
        if (count > 32)
            count = 32;
        chain_x[0] = head_step(longint'(tx), longint'(chain_x[0]));
        chain_y[0] = head_step(longint'(ty), longint'(chain_y[0]));
        for (int i = 1; i < count; i++)
        begin
            px = chain_x[i-1];
            py = chain_y[i-1];
            vx = px - longint'(chain_x[i]);
            vy = py - longint'(chain_y[i]);
            ax = vx < 0 ? -vx : vx;
            ay = vy < 0 ? -vy : vy;
            m2 = ax * ax + ay * ay;
            if (m2 == 0)
            begin
                // node on top of its predecessor: put it link_length to the left
                chain_x[i] = clamp_q16(px - longint'(link_len));
                chain_y[i] = clamp_q16(py);
            end
            else
            begin
                root = floor_root(m2 << 14);
                qx = (ax * longint'(link_len) * 128 + root / 2) / root;
                qy = (ay * longint'(link_len) * 128 + root / 2) / root;
                chain_x[i] = clamp_q16(px - (vx < 0 ? -longint'(qx) : longint'(qx)));
                chain_y[i] = clamp_q16(py - (vy < 0 ? -longint'(qy) : longint'(qy)));
            end
        end
        for (int i = 0; i < count; i++)
        begin
            w.idx  = i[4:0];
            w.x    = chain_x[i];
            w.y    = chain_y[i];
            w.last = (i == count - 1);
            node_q = {node_q, w};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        node_word_t exp_w;
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
            begin
                chain_x[i] = clamp_q16((1 - 50 * longint'(i)) * 256);
                chain_y[i] = 24'sd256;
            end
            link_len = fcu_pkg::LINK_RST;
            gain     = fcu_pkg::GAIN_RST;
            n_active = fcu_pkg::ACT_RST;
            node_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    fcu_pkg::REG_LINK: link_len = pwdata[22:0];
                    fcu_pkg::REG_GAIN: gain     = pwdata[15:0];
                    fcu_pkg::REG_ACT:  n_active = pwdata[5:0];
                    default: ;  // unmapped: dropped
                endcase
            end
            // a node word handed over in this cycle is checked before a new target is predicted
            if (m_tvalid && m_tready)
            begin
                if (node_q.size() == 0)
                begin
                    $display("%0t: unexpected word idx=%0d x=%h y=%h last=%b", $time,
                             m_tdata[4:0], m_tdata[28:5], m_tdata[52:29], m_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_w = node_q.pop_front();
                    if (m_tdata[4:0] !== exp_w.idx || m_tdata[28:5] !== exp_w.x ||
                        m_tdata[52:29] !== exp_w.y || m_tlast !== exp_w.last)
                    begin
                        $display("%0t: mismatch exp idx=%0d x=%h y=%h last=%b", $time,
                                 exp_w.idx, exp_w.x, exp_w.y, exp_w.last);
                        $display("%0t:          act idx=%0d x=%h y=%h last=%b", $time,
                                 m_tdata[4:0], m_tdata[28:5], m_tdata[52:29], m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                advance_chain(s_tdata[23:0], s_tdata[47:24]);
        end
    end

endmodule

`default_nettype wire

[test/tb_follow_chain_update_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module tb_follow_chain_update_core;

    localparam int STALL_LIMIT = 60000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // target_x, target_y
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // node_index, node_x, node_y, pad
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int words_pending;
    int tx_idle_pct;   // sender gap odds, percent
    int rx_idle_pct;   // receiver stall odds, percent
    int quiet_cycles = 0;

    follow_chain_update_core DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    follow_chain_check u_check
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .words_pending(words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver back-pressure, re-rolled every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // one target word; s_tvalid stays high afterwards so back-to-back words
    // carry no forced gap
    task automatic send_target(input logic [23:0] x, input logic [23:0] y);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // register writes go in only once every node word has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_chain(input logic [22:0] link, input logic [15:0] g,
                             input logic [5:0] n);
        wait_drained();
        apb_write(fcu_pkg::REG_LINK, {9'h1FF, link});   // upper bits must be ignored
        apb_write(fcu_pkg::REG_GAIN, {16'hFFFF, g});
        apb_write(fcu_pkg::REG_ACT, {26'h3FFFFFF, n});
    endtask

    // mostly targets near the origin where the chain lives, some full range
    task automatic random_targets(input int n);
        logic [23:0] x;
        logic [23:0] y;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                x = 24'($urandom);
                y = 24'($urandom);
            end
            else
            begin
                x = 24'($signed($urandom_range(0, 131071)) - 65536);
                y = 24'($signed($urandom_range(0, 131071)) - 65536);
            end
            send_target(x, y);
        end
    endtask

    task automatic random_phase(input int n);
        for (int blk = 0; blk < n / 20; blk++)
        begin
            case ($urandom_range(0, 3))
                0: set_chain(23'($urandom_range(0, 8388607)), 16'($urandom),
                             6'($urandom_range(1, 6)));
                1: set_chain(23'($urandom_range(64, 20000)), 16'($urandom_range(0, 65535)),
                             6'($urandom_range(2, 8)));
                2: set_chain(23'($urandom_range(1000, 30000)),
                             16'($urandom_range(20000, 65535)), 6'($urandom_range(1, 4)));
                default: set_chain(23'd12800, 16'($urandom_range(100, 6000)), 6'd32);
            endcase
            random_targets(20);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_pct = 11;
        rx_idle_pct = 46;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset layout, field extremes
        send_target(24'h7FFFFF, 24'h7FFFFF);
        send_target(24'h800000, 24'h800000);
        send_target(24'h000000, 24'h000000);
        send_target(24'h7FFFFF, 24'h800000);
        send_target(24'hFFFFFF, 24'h000001);
        // zero link folds followers onto their leaders, full gain moves the head
        set_chain(23'd0, 16'hFFFF, 6'd32);
        send_target(24'h001000, 24'hFFF000);
        send_target(24'h002000, 24'h000100);
        // now every follower sits on its leader: the zero-length case
        set_chain(23'd12800, 16'hFFFF, 6'd32);
        send_target(24'h002000, 24'h000100);
        send_target(24'h7FFFFF, 24'h7FFFFF);
        // widest link drives followers into saturation; count below range
        set_chain(23'h7FFFFF, 16'd0, 6'd0);
        send_target(24'h123456, 24'h654321);
        set_chain(23'h7FFFFF, 16'h8000, 6'd63);
        send_target(24'h800000, 24'h7FFFFF);
        send_target(24'h000000, 24'h800000);
        // unmapped register must not disturb anything
        wait_drained();
        apb_write(2'd3, 32'hFFFFFFFF);
        set_chain(23'd256, 16'd131, 6'd1);
        send_target(24'h400000, 24'hC00000);
        send_target(24'h000080, 24'hFFFF80);

        random_phase(60);
        wait_drained();
        tx_idle_pct = 46;
        rx_idle_pct = 11;
        random_phase(60);
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(40);

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/fcu_pkg.sv
src/fcu_root_div.sv
src/follow_chain_update_core.sv
test/follow_chain_check.sv
test/tb_follow_chain_update_core.sv
